// ----- rtl/qrs_pkg.sv -----
// qrs_pkg: widths, result kind codes and payload types for the quadratic root solver
// depends on nothing; imported by every module of the block
package qrs_pkg;

  localparam int CW   = 16;
  localparam int OF   = 16;
  localparam int OW   = 32;
  localparam int DW   = 2 * CW + 3;
  localparam int MW   = 2 * CW + 2;
  localparam int SW   = MW / 2;
  localparam int RW   = SW + 3;
  localparam int DVW  = CW + 1;
  localparam int NUW  = SW + 2;
  localparam int NMW  = CW + 1;
  localparam int NW   = NMW + OF + 1;
  localparam int LANES = 3;

  localparam logic [1:0] KIND_TWO_REAL = 2'd0;
  localparam logic [1:0] KIND_DOUBLE   = 2'd1;
  localparam logic [1:0] KIND_COMPLEX  = 2'd2;
  localparam logic [1:0] KIND_DEGEN    = 2'd3;

  typedef struct packed {
    logic signed [CW-1:0] coef_quad;
    logic signed [CW-1:0] coef_lin;
    logic signed [CW-1:0] coef_const;
  } coef_t;

  typedef struct packed {
    logic signed [OW-1:0] root_one_real;
    logic signed [OW-1:0] root_two_real;
    logic signed [OW-1:0] imag_part;
    logic [1:0]           root_kind;
    logic                 saturated;
  } root_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic signed [CW-1:0] lin;
    logic                 quad_neg;
    logic [DVW-1:0]       dv;
  } sq_side_t;

  typedef struct packed {
    logic [MW-1:0] x;
    logic [SW-1:0] root;
    logic [RW-1:0] rem;
  } sq_work_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [LANES-1:0] neg;
    logic [DVW-1:0]   dv;
  } dv_side_t;

  typedef struct packed {
    logic [LANES-1:0][DVW-1:0] rem;
    logic [LANES-1:0][NW-1:0]  nq;
  } dv_work_t;

endpackage

// ----- rtl/qrs_front.sv -----
// qrs_front: product stage and discriminant stage, sets up the square root chain
// depends on qrs_pkg
module qrs_front import qrs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  coef_t    coef,
  output logic     out_valid,
  input  logic     out_ready,
  output sq_side_t side,
  output sq_work_t work
);

  logic                   vld1;
  logic signed [CW-1:0]   a1;
  logic signed [CW-1:0]   b1;
  logic signed [2*CW-1:0] bb1;
  logic signed [2*CW-1:0] ac1;
  logic                   rdy1;
  logic                   rdy2;
  logic signed [DW-1:0]   disc;
  logic signed [CW:0]     a2;
  logic [1:0]             kind_next;

  assign rdy2     = !out_valid || out_ready;
  assign rdy1     = !vld1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (rdy1) begin
      vld1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      a1  <= coef.coef_quad;
      b1  <= coef.coef_lin;
      bb1 <= coef.coef_lin * coef.coef_lin;
      ac1 <= coef.coef_quad * coef.coef_const;
    end
  end

  always_comb begin
    disc = DW'(bb1) - (DW'(ac1) <<< 2);
    a2   = {a1, 1'b0};
    if (a1 == '0) begin
      kind_next = KIND_DEGEN;
    end else if (disc > 0) begin
      kind_next = KIND_TWO_REAL;
    end else if (disc == 0) begin
      kind_next = KIND_DOUBLE;
    end else begin
      kind_next = KIND_COMPLEX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy2) begin
      out_valid <= vld1;
    end
    if (rdy2 && vld1) begin
      side.kind     <= kind_next;
      side.lin      <= b1;
      side.quad_neg <= a1[CW-1];
      side.dv       <= a2[CW] ? DVW'(-a2) : DVW'(a2);
      work.x        <= disc[DW-1] ? MW'(-disc) : MW'(disc);
      work.root     <= '0;
      work.rem      <= '0;
    end
  end

endmodule

// ----- rtl/qrs_sqrt_cell.sv -----
// qrs_sqrt_cell: one digit of the restoring integer square root
// depends on qrs_pkg
module qrs_sqrt_cell import qrs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  sq_side_t side_in,
  input  sq_work_t work_in,
  output logic     out_valid,
  input  logic     out_ready,
  output sq_side_t side_out,
  output sq_work_t work_out
);

  logic [RW-1:0] t;
  logic [RW-1:0] trial;
  logic          ge;
  sq_work_t      work_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    t         = {work_in.rem[RW-3:0], work_in.x[MW-1 -: 2]};
    trial     = RW'({work_in.root, 2'b01});
    ge        = t >= trial;
    work_next.rem  = ge ? t - trial : t;
    work_next.root = {work_in.root[SW-2:0], ge};
    work_next.x    = {work_in.x[MW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      side_out <= side_in;
      work_out <= work_next;
    end
  end

endmodule

// ----- rtl/qrs_div_cell.sv -----
// qrs_div_cell: one quotient bit of three restoring dividers sharing one divisor
// depends on qrs_pkg
module qrs_div_cell import qrs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dv_side_t side_in,
  input  dv_work_t work_in,
  output logic     out_valid,
  input  logic     out_ready,
  output dv_side_t side_out,
  output dv_work_t work_out
);

  logic [LANES-1:0][DVW:0] t;
  logic [LANES-1:0][DVW:0] tr;
  logic [LANES-1:0]        ge;
  dv_work_t                work_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      t[j]  = {work_in.rem[j], work_in.nq[j][NW-1]};
      ge[j] = t[j] >= {1'b0, side_in.dv};
      tr[j] = ge[j] ? t[j] - {1'b0, side_in.dv} : t[j];
      work_next.rem[j] = tr[j][DVW-1:0];
      work_next.nq[j]  = {work_in.nq[j][NW-2:0], ge[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      side_out <= side_in;
      work_out <= work_next;
    end
  end

endmodule

// ----- rtl/qrs_finish.sv -----
// qrs_finish: sign, clipping and result selection, holds the output register
// depends on qrs_pkg
module qrs_finish import qrs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dv_side_t side_in,
  input  dv_work_t work_in,
  output logic     out_valid,
  input  logic     out_ready,
  output root_t    root
);

  function automatic logic [OW:0] clip(input logic [NW-1:0] q, input logic neg,
                                       input logic sym);
    logic          n;
    logic [NW-1:0] lim;
    logic [NW-1:0] qc;
    logic          sat;
    logic [OW-1:0] q32;
    n   = neg && (q != '0);
    lim = (n && !sym) ? NW'(33'h080000000) : NW'(33'h07FFFFFFF);
    sat = q > lim;
    qc  = sat ? lim : q;
    q32 = qc[OW-1:0];
    return {sat, n ? -q32 : q32};
  endfunction

  logic [OW:0] v1;
  logic [OW:0] v2;
  logic [OW:0] v3;
  root_t       root_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    v1 = clip(work_in.nq[0], side_in.neg[0], 1'b0);
    v2 = clip(work_in.nq[1], side_in.neg[1], 1'b0);
    v3 = clip(work_in.nq[2], side_in.neg[2], 1'b1);
    root_next.root_kind = side_in.kind;
    case (side_in.kind)
      KIND_TWO_REAL: begin
        root_next.root_one_real = v1[OW-1:0];
        root_next.root_two_real = v2[OW-1:0];
        root_next.imag_part     = '0;
        root_next.saturated     = v1[OW] | v2[OW];
      end
      KIND_DOUBLE: begin
        root_next.root_one_real = v1[OW-1:0];
        root_next.root_two_real = v1[OW-1:0];
        root_next.imag_part     = '0;
        root_next.saturated     = v1[OW];
      end
      KIND_COMPLEX: begin
        root_next.root_one_real = v1[OW-1:0];
        root_next.root_two_real = v1[OW-1:0];
        root_next.imag_part     = v3[OW-1:0];
        root_next.saturated     = v1[OW] | v3[OW];
      end
      default: begin
        root_next.root_one_real = '0;
        root_next.root_two_real = '0;
        root_next.imag_part     = '0;
        root_next.saturated     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      root <= root_next;
    end
  end

endmodule

// ----- rtl/quadratic_root_solver.sv -----
// quadratic_root_solver: roots of a*x^2 + b*x + c in Q16.16 from Q8.8 coefficients
// depends on qrs_pkg, qrs_front, qrs_sqrt_cell, qrs_div_cell, qrs_finish
//
//   channel  valid        ready        payload
//   input    coef_valid   coef_ready   coef  (coef_t)
//   output   root_valid   root_ready   root  (root_t)
//
// one transfer per cycle while the output is not stalled; items pass the front
// stages, the square root row (one cell per root bit), the divider row (one cell
// per quotient bit) and the finish register. every cell holds its item until the
// next takes it, so an output stall backs up cell by cell and bubbles close up.
// reset is synchronous and clears only the valid flags.
module quadratic_root_solver import qrs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  coef_valid,
  output logic  coef_ready,
  input  coef_t coef,
  output logic  root_valid,
  input  logic  root_ready,
  output root_t root
);

  sq_side_t sq_side  [0:SW];
  sq_work_t sq_work  [0:SW];
  logic     sq_valid [0:SW];
  logic     sq_ready [0:SW];

  dv_side_t dv_side  [0:NW];
  dv_work_t dv_work  [0:NW];
  logic     dv_valid [0:NW];
  logic     dv_ready [0:NW];

  logic signed [NUW-1:0] nb;
  logic signed [NUW-1:0] sw;
  logic signed [LANES-1:0][NUW-1:0] num;
  logic [NUW-1:0] mag;

  qrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (coef_valid),
    .in_ready  (coef_ready),
    .coef      (coef),
    .out_valid (sq_valid[0]),
    .out_ready (sq_ready[0]),
    .side      (sq_side[0]),
    .work      (sq_work[0])
  );

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_valid[i]),
      .in_ready  (sq_ready[i]),
      .side_in   (sq_side[i]),
      .work_in   (sq_work[i]),
      .out_valid (sq_valid[i+1]),
      .out_ready (sq_ready[i+1]),
      .side_out  (sq_side[i+1]),
      .work_out  (sq_work[i+1])
    );
  end

  always_comb begin
    nb = -NUW'(sq_side[SW].lin);
    sw = signed'({2'b00, sq_work[SW].root});
    num[0] = (sq_side[SW].kind == KIND_TWO_REAL) ? nb + sw : nb;
    num[1] = (sq_side[SW].kind == KIND_TWO_REAL) ? nb - sw : nb;
    num[2] = (sq_side[SW].kind == KIND_COMPLEX) ? sw : '0;
    dv_side[0].kind = sq_side[SW].kind;
    dv_side[0].dv   = sq_side[SW].dv;
    mag = '0;
    for (int j = 0; j < LANES; j++) begin
      mag = num[j][NUW-1] ? NUW'(-num[j]) : NUW'(num[j]);
      dv_side[0].neg[j] = num[j][NUW-1] ^ sq_side[SW].quad_neg;
      dv_work[0].rem[j] = '0;
      dv_work[0].nq[j]  = (NW'(mag[NMW-1:0]) << OF) + NW'(sq_side[SW].dv >> 1);
    end
  end

  assign dv_valid[0]  = sq_valid[SW];
  assign sq_ready[SW] = dv_ready[0];

  for (genvar i = 0; i < NW; i++) begin : g_div
    qrs_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv_valid[i]),
      .in_ready  (dv_ready[i]),
      .side_in   (dv_side[i]),
      .work_in   (dv_work[i]),
      .out_valid (dv_valid[i+1]),
      .out_ready (dv_ready[i+1]),
      .side_out  (dv_side[i+1]),
      .work_out  (dv_work[i+1])
    );
  end

  qrs_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_valid[NW]),
    .in_ready  (dv_ready[NW]),
    .side_in   (dv_side[NW]),
    .work_in   (dv_work[NW]),
    .out_valid (root_valid),
    .out_ready (root_ready),
    .root      (root)
  );

endmodule

// ----- verif/tb_quadratic_root_solver.sv -----
// tb_quadratic_root_solver: self-checking bench for the quadratic root solver
// depends on qrs_pkg and quadratic_root_solver; predicts each root set and checks
// every output transfer in order against it
`timescale 1ns / 1ps
module tb_quadratic_root_solver;
  import qrs_pkg::*;

  logic  clk;
  logic  rst;
  logic  coef_valid;
  logic  coef_ready;
  coef_t coef;
  logic  root_valid;
  logic  root_ready;
  root_t root;

  root_t pending_roots[$];
  int    mismatches;
  int    cycle_count;
  bit    idle_enable;

  quadratic_root_solver DUT (
    .clk(clk), .rst(rst),
    .coef_valid(coef_valid), .coef_ready(coef_ready), .coef(coef),
    .root_valid(root_valid), .root_ready(root_ready), .root(root)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // floor(sqrt(v))
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // num * 2^16 / den rounded half away from zero, clipped
  function automatic logic [31:0] q16_quotient(longint num, longint den, bit sym,
                                               inout bit sat);
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    longint unsigned lim;
    bit              neg;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = ((n << 16) + d / 2) / d;
    neg = ((num < 0) != (den < 0)) && q != 0;
    lim = neg ? (sym ? 64'h7FFF_FFFF : 64'h8000_0000) : 64'h7FFF_FFFF;
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    if (neg) return 32'(-q);
    return q[31:0];
  endfunction

  function automatic root_t solve_roots(coef_t cf);
    root_t           res;
    longint          a;
    longint          b;
    longint          c;
    longint          disc;
    longint unsigned s;
    bit              sat;
    a = cf.coef_quad;
    b = cf.coef_lin;
    c = cf.coef_const;
    sat = 1'b0;
    res = '0;
    res.root_kind = KIND_DEGEN;
    if (a == 0) return res;
    disc = b * b - 4 * a * c;
    if (disc > 0) begin
      s = int_sqrt(disc);
      res.root_one_real = q16_quotient(-b + longint'(s), 2 * a, 1'b0, sat);
      res.root_two_real = q16_quotient(-b - longint'(s), 2 * a, 1'b0, sat);
      res.root_kind = KIND_TWO_REAL;
    end else if (disc == 0) begin
      res.root_one_real = q16_quotient(-b, 2 * a, 1'b0, sat);
      res.root_two_real = res.root_one_real;
      res.root_kind = KIND_DOUBLE;
    end else begin
      s = int_sqrt(-disc);
      res.root_one_real = q16_quotient(-b, 2 * a, 1'b0, sat);
      res.root_two_real = res.root_one_real;
      res.imag_part = q16_quotient(longint'(s), 2 * a, 1'b1, sat);
      res.root_kind = KIND_COMPLEX;
    end
    res.saturated = sat;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", field, got, want,
             cycle_count);
    mismatches++;
  endtask

  task automatic send_coef(logic signed [15:0] a, logic signed [15:0] b,
                           logic signed [15:0] c);
    coef_t cf;
    cf.coef_quad = a;
    cf.coef_lin = b;
    cf.coef_const = c;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      coef_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    coef_valid <= 1'b1;
    coef <= cf;
    @(posedge clk);
    while (!coef_ready) @(posedge clk);
    pending_roots.push_back(solve_roots(cf));
  endtask

  // output side stall bursts
  initial begin
    root_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
        root_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      root_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    root_t want;
    if (!rst && root_valid && root_ready) begin
      if (pending_roots.size() == 0) begin
        report_mismatch("unexpected transfer", 32'h0, 32'h0);
      end else begin
        want = pending_roots.pop_front();
        if (root.root_one_real !== want.root_one_real)
          report_mismatch("root_one_real", root.root_one_real, want.root_one_real);
        if (root.root_two_real !== want.root_two_real)
          report_mismatch("root_two_real", root.root_two_real, want.root_two_real);
        if (root.imag_part !== want.imag_part)
          report_mismatch("imag_part", root.imag_part, want.imag_part);
        if (root.root_kind !== want.root_kind)
          report_mismatch("root_kind", 32'(root.root_kind), 32'(want.root_kind));
        if (root.saturated !== want.saturated)
          report_mismatch("saturated", 32'(root.saturated), 32'(want.saturated));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("** quadratic_root_solver: FAILED **");
      $finish;
    end
  end

  task automatic test_extremes();
    send_coef(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_coef(-16'sh8000, -16'sh8000, -16'sh8000);
    send_coef(16'sh0001, -16'sh8000, -16'sh8000);
    send_coef(16'sh0001, 16'sh7FFF, 16'sh0000);
    send_coef(-16'sh0001, -16'sh8000, 16'sh7FFF);
    send_coef(16'sh0001, 16'sh0000, 16'sh7FFF);
    send_coef(-16'sh8000, 16'sh0001, 16'sh0000);
    send_coef(16'sh7FFF, 16'sh0000, 16'sh0000);
    send_coef(16'sh5555, -16'sh2AAB, 16'sh5555);
  endtask

  task automatic test_root_kinds();
    send_coef(16'sh0100, -16'sh0300, 16'sh0200);
    send_coef(16'sh0100, 16'sh0200, 16'sh0100);
    send_coef(16'sh0100, 16'sh0000, 16'sh0100);
    send_coef(16'sh0000, 16'sh0123, 16'sh0456);
    send_coef(16'sh0000, 16'sh0000, 16'sh0000);
    send_coef(16'sh0001, 16'sh0002, 16'sh0001);
    send_coef(16'sh0001, 16'sh0001, 16'sh0000);
    send_coef(-16'sh0200, 16'sh0400, -16'sh0200);
    send_coef(16'sh0300, 16'sh0001, 16'sh0200);
  endtask

  task automatic test_saturation();
    send_coef(16'sh0001, 16'sh7FFF, -16'sh8000);
    send_coef(16'sh0001, 16'sh0000, -16'sh8000);
    send_coef(-16'sh0001, 16'sh0000, -16'sh8000);
    send_coef(16'sh0001, -16'sh8000, 16'sh0000);
    send_coef(-16'sh0001, -16'sh8000, 16'sh0000);
  endtask

  task automatic test_random(int count);
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    int                 sel;
    repeat (count) begin
      a = 16'($urandom);
      b = 16'($urandom);
      c = 16'($urandom);
      sel = $urandom_range(0, 9);
      if (sel == 0) a = 0;
      else if (sel == 1) c = 16'((b * b) / (4 * (a == 0 ? 1 : a)));
      else if (sel == 2) a = 16'($signed(16'($urandom_range(0, 7))) - 3);
      else if (sel == 3) begin
        a = 16'($urandom_range(1, 4) * 16'sh0100);
        b = 16'(2 * a * ($signed(16'($urandom_range(0, 8))) - 4));
        c = 16'((b / 2) * (b / 2) / a);
      end
      send_coef(a, b, c);
    end
  endtask

  initial begin
    rst = 1'b1;
    coef_valid = 1'b0;
    coef = '0;
    mismatches = 0;
    idle_enable = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_root_kinds();
    test_saturation();
    test_random(350);
    idle_enable = 1'b0;
    test_random(100);
    coef_valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_roots.size() == 0) begin
      $display("** quadratic_root_solver: PASSED **");
    end else begin
      $display("** quadratic_root_solver: FAILED **");
    end
    $finish;
  end

endmodule
